// File: rtl/esg_pkg.sv
package esg_pkg;

    localparam int COORD_BITS = 12;
    localparam int STEP_BITS  = COORD_BITS - 1;
    localparam int AX_BITS    = COORD_BITS - 1;
    localparam int SQ_BITS    = 2 * AX_BITS;
    localparam int NUM_BITS   = 4 * AX_BITS;

    typedef struct packed {
        logic [COORD_BITS-1:0] first_x;
        logic [COORD_BITS-1:0] first_y;
        logic [COORD_BITS-1:0] second_x;
        logic [COORD_BITS-1:0] second_y;
        logic [STEP_BITS-1:0]  step_index;
    } t_in_req;

    typedef struct packed {
        logic                  seg_valid;
        logic                  last_step;
        logic [COORD_BITS-1:0] seg_start_x;
        logic [COORD_BITS:0]   seg_end_x;
        logic [COORD_BITS-1:0] upper_start_y;
        logic [COORD_BITS-1:0] upper_end_y;
        logic [COORD_BITS-1:0] lower_start_y;
        logic [COORD_BITS-1:0] lower_end_y;
    } t_out_req;

    typedef struct packed {
        logic                  seg_valid;
        logic                  last_step;
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS:0]   end_x;
        logic [COORD_BITS-1:0] k;
        logic                  exact_s;
        logic                  exact_e;
    } t_side;

endpackage

// File: rtl/esg_div_cell.sv
module esg_div_cell #(
    parameter int W = 22
) (
    input  logic         i_clk,
    input  logic         i_load,
    input  logic [W-1:0] i_rem,
    input  logic [W-1:0] i_low,
    input  logic [W-1:0] i_quo,
    input  logic [W-1:0] i_den,
    output logic [W-1:0] o_rem,
    output logic [W-1:0] o_low,
    output logic [W-1:0] o_quo,
    output logic [W-1:0] o_den
);

    logic [W:0] t;
    logic [W:0] diff;
    logic       ge;

    always_comb begin
        t    = {i_rem, i_low[W-1]};
        diff = t - {1'b0, i_den};
        ge   = (t >= {1'b0, i_den});
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            o_rem <= ge ? diff[W-1:0] : t[W-1:0];
            o_low <= {i_low[W-2:0], 1'b0};
            o_quo <= {i_quo[W-2:0], ge};
            o_den <= i_den;
        end
    end

endmodule

// File: rtl/esg_sqrt_cell.sv
module esg_sqrt_cell #(
    parameter int N = 11
) (
    input  logic           i_clk,
    input  logic           i_load,
    input  logic [2*N-1:0] i_rad,
    input  logic [N+1:0]   i_rem,
    input  logic [N-1:0]   i_root,
    output logic [2*N-1:0] o_rad,
    output logic [N+1:0]   o_rem,
    output logic [N-1:0]   o_root
);

    logic [N+3:0] t;
    logic [N+3:0] trial;
    logic [N+3:0] diff;
    logic         ge;

    always_comb begin
        t     = {i_rem, i_rad[2*N-1:2*N-2]};
        trial = {2'b00, i_root, 2'b01};
        diff  = t - trial;
        ge    = (t >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            o_rem  <= ge ? diff[N+1:0] : t[N+1:0];
            o_root <= {i_root[N-2:0], ge};
            o_rad  <= {i_rad[2*N-3:0], 2'b00};
        end
    end

endmodule

// File: rtl/ellipse_segment_generator.sv
// Ellipse segment generator.
// Input channel: i_valid / o_stall with request i_req (two box corners and a
// step number). Output channel: o_valid / i_stall with request o_req (the
// start/end x and the upper/lower y of one two-pixel column of the ellipse).
// A request is taken on a clock edge with valid high and stall low.
// The pipeline is 4 + 3*(COORD_BITS-1) stages deep. Front stage orders the
// box, two multiply stages, then one restoring-divide cell per quotient bit
// (22) and one square-root cell per root bit (11), then the output register.
// Throughput is one request per clock while i_stall is low. Each stage
// moves forward when it is empty or its successor moves, so bubbles are
// squeezed out; when the receiver stalls the output holds and the pipe
// fills, and o_stall rises only once every stage holds a request.
// Reset (synchronous, i_rst_n low) drops all requests in flight.
// Steps at or beyond the half width come out with all fields zero.
module ellipse_segment_generator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  esg_pkg::t_in_req  i_req,
    output logic              o_valid,
    input  logic              i_stall,
    output esg_pkg::t_out_req o_req
);
    import esg_pkg::*;

    localparam int DIV0  = 3;
    localparam int SQ0   = DIV0 + SQ_BITS;
    localparam int OUTS  = SQ0 + AX_BITS;
    localparam int NST   = OUTS + 1;

    logic [NST-1:0] r_v;
    logic [NST-1:0] adv;
    t_side          r_side [OUTS];
    t_side          n_side0;
    t_side          n_sq;
    t_out_req       r_out;

    logic [AX_BITS-1:0] r_a, r_b, r_ds, r_de;
    logic [AX_BITS-1:0] n_a, n_b, n_ds, n_de;
    logic [SQ_BITS-1:0] r_a2, r_b2, r_ds2, r_de2;

    logic [SQ_BITS-1:0]  d_rem [2][SQ_BITS+1];
    logic [SQ_BITS-1:0]  d_low [2][SQ_BITS+1];
    logic [SQ_BITS-1:0]  d_quo [2][SQ_BITS+1];
    logic [SQ_BITS-1:0]  d_den [2][SQ_BITS+1];
    logic [SQ_BITS-1:0]  s_rad [2][AX_BITS+1];
    logic [AX_BITS+1:0]  s_rem [2][AX_BITS+1];
    logic [AX_BITS-1:0]  s_root[2][AX_BITS+1];

    always_comb begin
        adv[NST-1] = !r_v[NST-1] || !i_stall;
        for (int i = NST - 2; i >= 0; i--) begin
            adv[i] = !r_v[i] || adv[i+1];
        end
    end

    assign o_stall = !adv[0];
    assign o_valid = r_v[NST-1];
    assign o_req   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_valid;
            end
            for (int i = 1; i < NST; i++) begin
                if (adv[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    // front stage: order corners, half axes, distances from center
    logic [COORD_BITS-1:0] xmin, xmax, ymin, ymax, dx, dy;
    logic [COORD_BITS:0]   j2, j2p, a13, sx13, ds13, de13;

    always_comb begin
        xmin = (i_req.first_x < i_req.second_x) ? i_req.first_x : i_req.second_x;
        xmax = (i_req.first_x < i_req.second_x) ? i_req.second_x : i_req.first_x;
        ymin = (i_req.first_y < i_req.second_y) ? i_req.first_y : i_req.second_y;
        ymax = (i_req.first_y < i_req.second_y) ? i_req.second_y : i_req.first_y;
        dx   = xmax - xmin;
        dy   = ymax - ymin;
        n_a  = dx[COORD_BITS-1:1];
        n_b  = dy[COORD_BITS-1:1];
        j2   = {1'b0, i_req.step_index, 1'b0};
        j2p  = j2 + (COORD_BITS+1)'(2);
        a13  = {2'b00, n_a};
        sx13 = {1'b0, xmin} + j2;
        ds13 = (j2 >= a13) ? (j2 - a13) : (a13 - j2);
        de13 = (j2p >= a13) ? (j2p - a13) : (a13 - j2p);
        n_ds = ds13[AX_BITS-1:0];
        n_de = de13[AX_BITS-1:0];
        n_side0.seg_valid = (i_req.step_index < n_a);
        n_side0.last_step = n_side0.seg_valid
                            && ((i_req.step_index + STEP_BITS'(1)) == n_a);
        n_side0.start_x   = sx13[COORD_BITS-1:0];
        n_side0.end_x     = sx13 + (COORD_BITS+1)'(2);
        n_side0.k         = ymin + {1'b0, n_b};
        n_side0.exact_s   = 1'b0;
        n_side0.exact_e   = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_a  <= n_a;
            r_b  <= n_b;
            r_ds <= n_ds;
            r_de <= n_de;
        end
        if (adv[1]) begin
            r_a2  <= r_a * r_a;
            r_b2  <= r_b * r_b;
            r_ds2 <= r_ds * r_ds;
            r_de2 <= r_de * r_de;
        end
    end

    // stage 2: numerator b^2*(a^2-d^2), divisor a^2 (forced to 0/1 outside)
    logic [SQ_BITS-1:0] ds2_in [2];
    assign ds2_in[0] = r_ds2;
    assign ds2_in[1] = r_de2;

    for (genvar c = 0; c < 2; c++) begin : g_ch
        logic               zero_h;
        logic [SQ_BITS-1:0] gap;
        logic [NUM_BITS-1:0] num;

        always_comb begin
            zero_h = (r_a2 == '0) || (ds2_in[c] >= r_a2);
            gap    = r_a2 - ds2_in[c];
            num    = r_b2 * gap;
        end

        always_ff @(posedge i_clk) begin
            if (adv[2]) begin
                d_rem[c][0] <= zero_h ? '0 : num[NUM_BITS-1:SQ_BITS];
                d_low[c][0] <= zero_h ? '0 : num[SQ_BITS-1:0];
                d_quo[c][0] <= '0;
                d_den[c][0] <= zero_h ? SQ_BITS'(1) : r_a2;
            end
        end

        for (genvar i = 0; i < SQ_BITS; i++) begin : g_div
            esg_div_cell #(.W(SQ_BITS)) u_div (
                .i_clk  (i_clk),
                .i_load (adv[DIV0+i]),
                .i_rem  (d_rem[c][i]),
                .i_low  (d_low[c][i]),
                .i_quo  (d_quo[c][i]),
                .i_den  (d_den[c][i]),
                .o_rem  (d_rem[c][i+1]),
                .o_low  (d_low[c][i+1]),
                .o_quo  (d_quo[c][i+1]),
                .o_den  (d_den[c][i+1])
            );
        end

        assign s_rad[c][0]  = d_quo[c][SQ_BITS];
        assign s_rem[c][0]  = '0;
        assign s_root[c][0] = '0;

        for (genvar i = 0; i < AX_BITS; i++) begin : g_sq
            esg_sqrt_cell #(.N(AX_BITS)) u_sq (
                .i_clk  (i_clk),
                .i_load (adv[SQ0+i]),
                .i_rad  (s_rad[c][i]),
                .i_rem  (s_rem[c][i]),
                .i_root (s_root[c][i]),
                .o_rad  (s_rad[c][i+1]),
                .o_rem  (s_rem[c][i+1]),
                .o_root (s_root[c][i+1])
            );
        end
    end

    always_comb begin
        n_sq         = r_side[SQ0-1];
        n_sq.exact_s = (d_rem[0][SQ_BITS] == '0);
        n_sq.exact_e = (d_rem[1][SQ_BITS] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_side[0] <= n_side0;
        end
        for (int i = 1; i < OUTS; i++) begin
            if (adv[i]) begin
                r_side[i] <= (i == SQ0) ? n_sq : r_side[i-1];
            end
        end
    end

    // output stage
    t_side               lst;
    logic [AX_BITS:0]    cs, ce;
    t_out_req            n_out;

    always_comb begin
        lst = r_side[OUTS-1];
        cs  = {1'b0, s_root[0][AX_BITS]}
              + (AX_BITS+1)'(!(lst.exact_s && (s_rem[0][AX_BITS] == '0)));
        ce  = {1'b0, s_root[1][AX_BITS]}
              + (AX_BITS+1)'(!(lst.exact_e && (s_rem[1][AX_BITS] == '0)));
        n_out = '0;
        if (lst.seg_valid) begin
            n_out.seg_valid     = 1'b1;
            n_out.last_step     = lst.last_step;
            n_out.seg_start_x   = lst.start_x;
            n_out.seg_end_x     = lst.end_x;
            n_out.upper_start_y = lst.k + {1'b0, s_root[0][AX_BITS]};
            n_out.upper_end_y   = lst.k + {1'b0, s_root[1][AX_BITS]};
            n_out.lower_start_y = lst.k - cs;
            n_out.lower_end_y   = lst.k - ce;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[OUTS]) begin
            r_out <= n_out;
        end
    end

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while pipe not full");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("request out right after reset");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_req.seg_valid) |->
        (o_req.last_step == 1'b0 && o_req.seg_start_x == '0 && o_req.seg_end_x == '0
         && o_req.upper_start_y == '0 && o_req.lower_end_y == '0))
        else $error("out-of-range step with nonzero fields");

    a_upper_lower: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_req.seg_valid) |->
        (o_req.upper_start_y >= o_req.lower_start_y
         && o_req.upper_end_y >= o_req.lower_end_y))
        else $error("upper y below lower y");

endmodule
